// ----- rtl/core/lspe_pkg.sv -----
// Shared constants, types and helper functions of the line sensor position estimator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lspe_pkg;

	// Geometry of the sensor row and sample width.
	localparam int NUM_SENSORS = 9;
	localparam int SAMPLE_BITS = 12;

	// Sensor weights step by this amount and are centered on the middle sensor.
	localparam int WEIGHT_STEP = 10;
	localparam int CENTER      = (NUM_SENSORS - 1) / 2;

	// Running weight sum is signed and bounded well below step * n * n.
	localparam int SUM_BITS = $clog2(WEIGHT_STEP * NUM_SENSORS * NUM_SENSORS) + 1;
	localparam int CNT_BITS = $clog2(NUM_SENSORS + 1);
	localparam int POS_BITS = 7;

	// Configuration port.
	localparam int CFG_BITS = 2;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [CFG_BITS-1:0] {
		REG_FIRST_THRESHOLD = 2'd0,
		REG_WHITE_LIMIT     = 2'd1,
		REG_BLACK_LIMIT     = 2'd2,
		REG_STEP_LIMIT      = 2'd3
	} reg_idx_t;

	localparam sample_t FIRST_THRESHOLD_RST = sample_t'(1000);
	localparam sample_t WHITE_LIMIT_RST     = sample_t'(200);
	localparam sample_t BLACK_LIMIT_RST     = sample_t'(1200);
	localparam sample_t STEP_LIMIT_RST      = sample_t'(700);

	// Classification settings seen by every cell.
	typedef struct packed {
		sample_t first_threshold;
		sample_t white_limit;
		sample_t black_limit;
		sample_t step_limit;
	} cfg_t;

	// Partial result handed from one cell to the next.
	typedef struct packed {
		logic signed [SUM_BITS-1:0] sum;
		logic [CNT_BITS-1:0]        cnt;
		logic                       pair;
		logic                       last_black;
	} token_t;

	// Fixed weight of sensor i.
	function automatic logic signed [SUM_BITS-1:0] weight(input int i);
		return SUM_BITS'(WEIGHT_STEP * i - WEIGHT_STEP * CENTER);
	endfunction

endpackage

// ----- rtl/core/lspe_if.sv -----
// Handshake channels of the line sensor position estimator: sample frames in, results out.
// Depends on lspe_pkg for the field widths.
interface lspe_frame_if;
	logic                              valid;
	logic                              ready;
	logic [lspe_pkg::SAMPLE_BITS-1:0] sample_0;
	logic [lspe_pkg::SAMPLE_BITS-1:0] sample_1;
	logic [lspe_pkg::SAMPLE_BITS-1:0] sample_2;
	logic [lspe_pkg::SAMPLE_BITS-1:0] sample_3;
	logic [lspe_pkg::SAMPLE_BITS-1:0] sample_4;
	logic [lspe_pkg::SAMPLE_BITS-1:0] sample_5;
	logic [lspe_pkg::SAMPLE_BITS-1:0] sample_6;
	logic [lspe_pkg::SAMPLE_BITS-1:0] sample_7;
	logic [lspe_pkg::SAMPLE_BITS-1:0] sample_8;

	modport source (
		output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		       sample_5, sample_6, sample_7, sample_8,
		input  ready
	);
	modport sink (
		input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		       sample_5, sample_6, sample_7, sample_8,
		output ready
	);
endinterface

interface lspe_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [lspe_pkg::POS_BITS-1:0] position;
	logic                                  line_lost;
	logic [lspe_pkg::NUM_SENSORS-1:0]     black_mask;
	logic                                  adjacent_pair;

	modport source (
		output valid, position, line_lost, black_mask, adjacent_pair,
		input  ready
	);
	modport sink (
		input  valid, position, line_lost, black_mask, adjacent_pair,
		output ready
	);
endinterface

// ----- rtl/core/lspe_cell.sv -----
// One sensor cell: keeps the sensor's previous sample and color, and adds its
// contribution to the partial sum token passed along the row. Depends on lspe_pkg.
module lspe_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  logic                                  first,
	input  lspe_pkg::cfg_t                        cfg,
	input  lspe_pkg::sample_t                     sample,
	input  logic signed [lspe_pkg::SUM_BITS-1:0] wgt,
	input  lspe_pkg::token_t                      tok_in,
	output lspe_pkg::token_t                      tok_q,
	output logic                                  black
);

	lspe_pkg::sample_t                prev_q;
	logic                             color_q;
	logic                             color_d;
	logic [lspe_pkg::SAMPLE_BITS:0]   rise_lim;
	logic [lspe_pkg::SAMPLE_BITS:0]   fall_val;
	lspe_pkg::token_t                 tok_d;

	// Classify: first frame by threshold, else by limits, then step from the old sample.
	always_comb begin
		rise_lim = {1'b0, prev_q} + {1'b0, cfg.step_limit};
		fall_val = {1'b0, sample} + {1'b0, cfg.step_limit};
		color_d  = color_q;
		if (first) begin
			color_d = sample > cfg.first_threshold;
		end else if (sample < cfg.white_limit) begin
			color_d = 1'b0;
		end else if (sample > cfg.black_limit) begin
			color_d = 1'b1;
		end else if ({1'b0, sample} > rise_lim) begin
			color_d = 1'b1;
		end else if (fall_val < {1'b0, prev_q}) begin
			color_d = 1'b0;
		end
	end

	// The state is written only when a frame is taken; before that it affects no result.
	always_ff @(posedge clk) begin
		if (load) begin
			prev_q  <= sample;
			color_q <= color_d;
		end
	end

	// Add this sensor to the token coming from the left neighbor.
	always_comb begin
		tok_d.sum        = tok_in.sum + (color_q ? wgt : '0);
		tok_d.cnt        = tok_in.cnt + lspe_pkg::CNT_BITS'(color_q);
		tok_d.pair       = tok_in.pair | (tok_in.last_black & color_q);
		tok_d.last_black = color_q;
	end

	// The token moves one cell to the right every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign black = color_q;

endmodule

// ----- rtl/core/lspe_div.sv -----
// Restoring divider of the signed weight sum by the black sensor count, one
// quotient bit per cycle, truncating toward zero. Depends on lspe_pkg.
module lspe_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [lspe_pkg::SUM_BITS-1:0] dividend,
	input  logic [lspe_pkg::CNT_BITS-1:0]        divisor,
	output logic                                  done,
	output logic signed [lspe_pkg::SUM_BITS-1:0] quotient
);

	localparam int STEP_BITS = $clog2(lspe_pkg::SUM_BITS + 1);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_BITS-1:0]          step_q;
	logic [lspe_pkg::SUM_BITS-1:0] mag_q;
	logic [lspe_pkg::CNT_BITS-1:0] rem_q;
	logic [lspe_pkg::CNT_BITS-1:0] div_q;
	logic                          neg_q;
	logic [lspe_pkg::CNT_BITS:0]   shifted;
	logic                          fits;

	// Bring down the next dividend bit and test the divisor against the partial remainder.
	always_comb begin
		shifted = {rem_q, mag_q[lspe_pkg::SUM_BITS-1]};
		fits    = shifted >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			mag_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				neg_q  <= dividend[lspe_pkg::SUM_BITS-1];
				mag_q  <= dividend[lspe_pkg::SUM_BITS-1] ? -dividend : dividend;
				rem_q  <= '0;
				div_q  <= divisor;
			end else if (busy_q) begin
				// Quotient bits shift in from the right as dividend bits leave on the left.
				mag_q  <= {mag_q[lspe_pkg::SUM_BITS-2:0], fits};
				rem_q  <= fits ? lspe_pkg::CNT_BITS'(shifted - {1'b0, div_q})
				               : lspe_pkg::CNT_BITS'(shifted);
				step_q <= step_q + 1'b1;
				if (step_q == STEP_BITS'(lspe_pkg::SUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// ----- rtl/core/line_sensor_position_estimator_top.sv -----
// Top level of the line sensor position estimator: configuration registers,
// control sequencer, the row of sensor cells and the divider. Depends on lspe_pkg,
// lspe_frame_if, lspe_result_if, lspe_cell and lspe_div.
//
// Usage:
// A frame of nine samples is taken on the frame channel when valid and ready are
// both high. The cells classify every sensor in the cycle of the request and store
// the samples. A sum token then travels down the cell row, one cell per cycle,
// while the sequencer waits in S_SWEEP; a restoring divider then works through
// the bits of the weight sum in S_DIV to form the mean position.
// S_OUT moves the result into the output register and returns to idle; no new frame
// is taken while one is in progress, from the request up to that return.
// The result sits in an output register; a new frame is accepted while it waits.
// If the receiver is still stalling when the next result is ready, the block
// holds it and takes no further frame until the output register is free.
// Reset loads the register defaults, marks the next frame as the first one and
// empties the output register. Configuration writes on wr_en/wr_index/wr_data are
// meant for idle periods only.
module line_sensor_position_estimator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	lspe_frame_if.sink                     frame,
	lspe_result_if.source                  result,
	input  logic                           wr_en,
	input  logic [lspe_pkg::CFG_BITS-1:0]  wr_index,
	input  logic [lspe_pkg::SAMPLE_BITS-1:0] wr_data
);

	localparam int N        = lspe_pkg::NUM_SENSORS;
	localparam int SWP_BITS = $clog2(N);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_START,
		S_DIV,
		S_OUT
	} state_t;

	state_t                               state_q;
	logic [SWP_BITS-1:0]                  sweep_q;
	logic                                 first_q;
	lspe_pkg::cfg_t                       cfg_q;
	lspe_pkg::sample_t                    samples [N];
	lspe_pkg::token_t                     chain [N+1];
	logic [N-1:0]                         mask;
	logic                                 accept;
	logic                                 div_done;
	logic signed [lspe_pkg::SUM_BITS-1:0] quot;
	logic                                 out_free;

	logic                                 res_valid_q;
	logic signed [lspe_pkg::POS_BITS-1:0] position_q;
	logic                                 lost_q;
	logic [N-1:0]                         mask_q;
	logic                                 pair_q;

	assign accept   = frame.valid && frame.ready;
	assign out_free = !res_valid_q || result.ready;

	// Frame fields in sensor order.
	assign samples[0] = frame.sample_0;
	assign samples[1] = frame.sample_1;
	assign samples[2] = frame.sample_2;
	assign samples[3] = frame.sample_3;
	assign samples[4] = frame.sample_4;
	assign samples[5] = frame.sample_5;
	assign samples[6] = frame.sample_6;
	assign samples[7] = frame.sample_7;
	assign samples[8] = frame.sample_8;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_threshold <= lspe_pkg::FIRST_THRESHOLD_RST;
			cfg_q.white_limit     <= lspe_pkg::WHITE_LIMIT_RST;
			cfg_q.black_limit     <= lspe_pkg::BLACK_LIMIT_RST;
			cfg_q.step_limit      <= lspe_pkg::STEP_LIMIT_RST;
		end else if (wr_en) begin
			case (lspe_pkg::reg_idx_t'(wr_index))
				lspe_pkg::REG_FIRST_THRESHOLD: cfg_q.first_threshold <= wr_data;
				lspe_pkg::REG_WHITE_LIMIT:     cfg_q.white_limit     <= wr_data;
				lspe_pkg::REG_BLACK_LIMIT:     cfg_q.black_limit     <= wr_data;
				lspe_pkg::REG_STEP_LIMIT:      cfg_q.step_limit      <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Row of sensor cells; the token enters empty at the left end.
	assign chain[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		lspe_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (accept),
			.first  (first_q),
			.cfg    (cfg_q),
			.sample (samples[i]),
			.wgt    (lspe_pkg::weight(i)),
			.tok_in (chain[i]),
			.tok_q  (chain[i+1]),
			.black  (mask[i])
		);
	end

	// Mean position of the black sensors.
	lspe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START),
		.dividend (chain[N].sum),
		.divisor  (chain[N].cnt),
		.done     (div_done),
		.quotient (quot)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sweep_q     <= '0;
			first_q     <= 1'b1;
			res_valid_q <= 1'b0;
			position_q  <= '0;
			lost_q      <= 1'b0;
			mask_q      <= '0;
			pair_q      <= 1'b0;
		end else begin
			// The output register fills when a result is stored and empties when taken.
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						first_q <= 1'b0;
						sweep_q <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					// Wait until the token has passed the last cell.
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == SWP_BITS'(N - 1)) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						lost_q      <= chain[N].cnt == '0;
						position_q  <= (chain[N].cnt == '0) ? '0 : quot[lspe_pkg::POS_BITS-1:0];
						mask_q      <= mask;
						pair_q      <= chain[N].pair;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign frame.ready          = state_q == S_IDLE;
	assign result.valid         = res_valid_q;
	assign result.position      = position_q;
	assign result.line_lost     = lost_q;
	assign result.black_mask    = mask_q;
	assign result.adjacent_pair = pair_q;

	// A lost line reports a centered position and no neighboring pair.
	a_lost_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.line_lost |-> result.position == '0 && !result.adjacent_pair)
		else $error("lost line result carries a position or a pair");

	// The lost flag agrees with the black mask.
	a_lost_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.line_lost == (result.black_mask == '0))
		else $error("line_lost disagrees with black_mask");

	// A taken frame starts the sweep and closes the input.
	a_accept_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SWEEP && !frame.ready)
		else $error("frame request did not start the sweep");

	// The divider finishes only while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

endmodule

// ----- tb/tb_line_sensor_position_estimator_top.sv -----
// Self-checking testbench of the line sensor position estimator top level.
// Sends sample frames, predicts each centroid result and checks the results field by field.
// Depends on lspe_pkg, lspe_frame_if, lspe_result_if and line_sensor_position_estimator_top.
module tb_line_sensor_position_estimator_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_MAX     = (1 << lspe_pkg::SAMPLE_BITS) - 1;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SWEEP_FRAMES   = 90;

	typedef logic [lspe_pkg::NUM_SENSORS-1:0][lspe_pkg::SAMPLE_BITS-1:0] frame_t;

	typedef struct packed {
		logic signed [lspe_pkg::POS_BITS-1:0] position;
		logic                                 line_lost;
		logic [lspe_pkg::NUM_SENSORS-1:0]     black_mask;
		logic                                 adjacent_pair;
	} centroid_t;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          wr_en    = 1'b0;
	logic [lspe_pkg::CFG_BITS-1:0] wr_index = '0;
	lspe_pkg::sample_t             wr_data  = '0;

	lspe_frame_if  frame_ch();
	lspe_result_if result_ch();

	line_sensor_position_estimator_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Register copies and per-sensor state of the predictor.
	lspe_pkg::sample_t cfg_first  = lspe_pkg::FIRST_THRESHOLD_RST;
	lspe_pkg::sample_t cfg_white  = lspe_pkg::WHITE_LIMIT_RST;
	lspe_pkg::sample_t cfg_black  = lspe_pkg::BLACK_LIMIT_RST;
	lspe_pkg::sample_t cfg_change = lspe_pkg::STEP_LIMIT_RST;
	lspe_pkg::sample_t last_sample [lspe_pkg::NUM_SENSORS];
	logic              is_black    [lspe_pkg::NUM_SENSORS];
	logic              awaiting_first = 1'b1;

	centroid_t expected_centroids [$];

	int errors          = 0;
	int frames_sent     = 0;
	int results_checked = 0;
	int lost_seen       = 0;
	int settings_used   = 0;
	int stall_left      = 0;
	int idle_cycles     = 0;
	bit bursts_on       = 1'b1;

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Classify every sensor of a frame and form the mean weight of the black ones.
	function automatic centroid_t estimate_position(input frame_t f);
		centroid_t r;
		int        cur;
		int        sum;
		int        cnt;
		int        i;
		r   = '0;
		sum = 0;
		cnt = 0;
		for (i = 0; i < lspe_pkg::NUM_SENSORS; i++) begin
			cur = int'(f[i]);
			if (awaiting_first) begin
				is_black[i] = cur > int'(cfg_first);
			end else if (cur < int'(cfg_white)) begin
				is_black[i] = 1'b0;
			end else if (cur > int'(cfg_black)) begin
				is_black[i] = 1'b1;
			end else if (cur > int'(last_sample[i]) + int'(cfg_change)) begin
				is_black[i] = 1'b1;
			end else if (cur + int'(cfg_change) < int'(last_sample[i])) begin
				is_black[i] = 1'b0;
			end
			last_sample[i] = f[i];
		end
		awaiting_first = 1'b0;

		for (i = 0; i < lspe_pkg::NUM_SENSORS; i++) begin
			if (is_black[i]) begin
				sum += lspe_pkg::WEIGHT_STEP * (i - lspe_pkg::CENTER);
				cnt++;
				r.black_mask[i] = 1'b1;
				if (i + 1 < lspe_pkg::NUM_SENSORS && is_black[i + 1]) begin
					r.adjacent_pair = 1'b1;
				end
			end
		end
		r.line_lost = (cnt == 0);
		if (cnt != 0) begin
			r.position = lspe_pkg::POS_BITS'(sum / cnt);
		end
		return r;
	endfunction

	// Compare one accepted result with the oldest prediction.
	task automatic check_centroid();
		centroid_t want;
		if (expected_centroids.size() == 0) begin
			$error("Result with no frame pending: position %0d, black_mask %b",
				result_ch.position, result_ch.black_mask);
			errors++;
		end else begin
			want = expected_centroids.pop_front();
			if (result_ch.position !== want.position) begin
				$error("position: expected %0d, got %0d", want.position, result_ch.position);
				errors++;
			end
			if (result_ch.line_lost !== want.line_lost) begin
				$error("line_lost: expected %0b, got %0b", want.line_lost, result_ch.line_lost);
				errors++;
			end
			if (result_ch.black_mask !== want.black_mask) begin
				$error("black_mask: expected %b, got %b", want.black_mask, result_ch.black_mask);
				errors++;
			end
			if (result_ch.adjacent_pair !== want.adjacent_pair) begin
				$error("adjacent_pair: expected %0b, got %0b",
					want.adjacent_pair, result_ch.adjacent_pair);
				errors++;
			end
			results_checked++;
			if (want.line_lost) begin
				lost_seen++;
			end
		end
	endtask

	// Result side: check each accepted request, then choose ready for the next edge.
	always @(posedge clk) begin
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			check_centroid();
		end
		if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if (bursts_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Watchdog: ends the run when no request is accepted on either side for too long.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) ||
			    (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Timeout: no request accepted for %0d cycles.", WATCHDOG_LIMIT);
		$display("** line_sensor_position_estimator_top: FAILED **");
		$finish;
	end

	// Offer one frame, wait for its request to be accepted and record the prediction.
	// Valid stays high afterwards so that frames can follow back to back.
	task automatic send_frame(input frame_t f);
		int gap;
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 19);
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid    <= 1'b1;
		frame_ch.sample_0 <= f[0];
		frame_ch.sample_1 <= f[1];
		frame_ch.sample_2 <= f[2];
		frame_ch.sample_3 <= f[3];
		frame_ch.sample_4 <= f[4];
		frame_ch.sample_5 <= f[5];
		frame_ch.sample_6 <= f[6];
		frame_ch.sample_7 <= f[7];
		frame_ch.sample_8 <= f[8];
		do @(posedge clk); while (frame_ch.ready !== 1'b1);
		expected_centroids.push_back(estimate_position(f));
		frames_sent++;
	endtask

	// Stop offering frames, wait for every pending result, then let the pipeline settle.
	task automatic drain(input int extra);
		frame_ch.valid <= 1'b0;
		while (expected_centroids.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input lspe_pkg::reg_idx_t idx, input lspe_pkg::sample_t value);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
	endtask

	// Load all four registers while the block is idle.
	task automatic set_config(input lspe_pkg::sample_t first_thr, input lspe_pkg::sample_t wl,
	                          input lspe_pkg::sample_t bl, input lspe_pkg::sample_t ct);
		drain(SETTLE_CYCLES);
		write_reg(lspe_pkg::REG_FIRST_THRESHOLD, first_thr);
		write_reg(lspe_pkg::REG_WHITE_LIMIT, wl);
		write_reg(lspe_pkg::REG_BLACK_LIMIT, bl);
		write_reg(lspe_pkg::REG_STEP_LIMIT, ct);
		@(posedge clk);
		wr_en      <= 1'b0;
		cfg_first  = first_thr;
		cfg_white  = wl;
		cfg_black  = bl;
		cfg_change = ct;
		settings_used++;
	endtask

	// Build a frame that mostly follows the previous one, so that rises, falls and
	// holds around the step limit occur often; the rest is noise, limit values
	// and a clean line band.
	task automatic make_track_frame(output frame_t f);
		int kind;
		int reach;
		int band_lo;
		int band_hi;
		int v;
		int i;
		kind    = $urandom_range(0, 9);
		reach   = int'(cfg_change) + int'(cfg_change) / 2 + 64;
		band_lo = $urandom_range(0, lspe_pkg::NUM_SENSORS - 1);
		band_hi = band_lo + $urandom_range(0, 2);
		for (i = 0; i < lspe_pkg::NUM_SENSORS; i++) begin
			case (kind)
				0, 1, 2, 3, 4, 5: begin
					case ($urandom_range(0, 9))
						6: v = int'(last_sample[i]) + int'(cfg_change) + $urandom_range(0, 1);
						7: v = int'(last_sample[i]) - int'(cfg_change) - $urandom_range(0, 1);
						8: v = $urandom_range(cfg_white, cfg_black);
						9: v = $urandom_range(0, SAMPLE_MAX);
						default: v = int'(last_sample[i]) + int'($urandom_range(0, 2 * reach)) - reach;
					endcase
				end
				6, 7: begin
					v = $urandom_range(0, SAMPLE_MAX);
				end
				8: begin
					case ($urandom_range(0, 5))
						0: v = 0;
						1: v = SAMPLE_MAX;
						2: v = int'(cfg_white) - 1;
						3: v = int'(cfg_white);
						4: v = int'(cfg_black);
						default: v = int'(cfg_black) + 1;
					endcase
				end
				default: begin
					if (i >= band_lo && i <= band_hi) begin
						v = $urandom_range(cfg_black, SAMPLE_MAX);
					end else begin
						v = $urandom_range(0, cfg_white);
					end
				end
			endcase
			if (v < 0) begin
				v = 0;
			end else if (v > SAMPLE_MAX) begin
				v = SAMPLE_MAX;
			end
			f[i] = lspe_pkg::sample_t'(v);
		end
	endtask

	// The first frame after reset is judged by the first-frame threshold alone.
	task automatic test_first_frame();
		frame_t f;
		set_config(lspe_pkg::sample_t'(2047), lspe_pkg::WHITE_LIMIT_RST,
		           lspe_pkg::BLACK_LIMIT_RST, lspe_pkg::STEP_LIMIT_RST);
		f[0] = lspe_pkg::sample_t'(SAMPLE_MAX);
		f[1] = lspe_pkg::sample_t'(2048);
		f[2] = lspe_pkg::sample_t'(2047);
		f[3] = lspe_pkg::sample_t'(0);
		f[4] = lspe_pkg::sample_t'(1);
		f[5] = lspe_pkg::sample_t'(2046);
		f[6] = lspe_pkg::sample_t'(2049);
		f[7] = lspe_pkg::sample_t'(SAMPLE_MAX - 1);
		f[8] = lspe_pkg::sample_t'(1000);
		send_frame(f);
	endtask

	// Lost line, end sensors, truncation both ways, pairs, and every classification
	// rule at and just past its boundary.
	task automatic test_directed_cases();
		int     rows [12][lspe_pkg::NUM_SENSORS];
		frame_t f;
		int     k;
		int     i;
		rows = '{
			'{0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095},
			'{4095, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 0, 0, 0, 0, 0, 0, 4095},
			'{4095, 4095, 0, 0, 4095, 0, 0, 0, 0},
			'{0, 0, 0, 0, 4095, 0, 0, 4095, 4095},
			'{4095, 0, 4095, 0, 4095, 0, 4095, 0, 4095},
			'{300, 300, 300, 300, 300, 300, 300, 300, 300},
			'{1100, 1000, 1001, 200, 199, 1200, 1201, 300, 600},
			'{300, 301, 300, 900, 900, 499, 500, 300, 600},
			'{4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095},
			'{700, 700, 700, 700, 700, 700, 700, 700, 700}
		};
		for (k = 0; k < 12; k++) begin
			for (i = 0; i < lspe_pkg::NUM_SENSORS; i++) begin
				f[i] = lspe_pkg::sample_t'(rows[k][i]);
			end
			send_frame(f);
		end
	endtask

	// Random tracking frames under default, extreme and random register settings.
	task automatic test_register_sweep();
		frame_t f;
		int     k;
		int     n;
		for (k = 0; k < 8; k++) begin
			case (k)
				0: set_config(lspe_pkg::FIRST_THRESHOLD_RST, lspe_pkg::WHITE_LIMIT_RST,
				              lspe_pkg::BLACK_LIMIT_RST, lspe_pkg::STEP_LIMIT_RST);
				1: set_config(lspe_pkg::sample_t'(0), lspe_pkg::sample_t'(0),
				              lspe_pkg::sample_t'(SAMPLE_MAX), lspe_pkg::sample_t'(0));
				2: set_config(lspe_pkg::sample_t'(SAMPLE_MAX), lspe_pkg::sample_t'(0),
				              lspe_pkg::sample_t'(SAMPLE_MAX), lspe_pkg::sample_t'(SAMPLE_MAX));
				3: set_config(lspe_pkg::sample_t'($urandom_range(0, SAMPLE_MAX)),
				              lspe_pkg::sample_t'(SAMPLE_MAX), lspe_pkg::sample_t'(0),
				              lspe_pkg::sample_t'($urandom_range(0, SAMPLE_MAX)));
				4: set_config(lspe_pkg::sample_t'(0), lspe_pkg::sample_t'(0),
				              lspe_pkg::sample_t'(0), lspe_pkg::STEP_LIMIT_RST);
				5: set_config(lspe_pkg::sample_t'($urandom_range(0, SAMPLE_MAX)),
				              lspe_pkg::sample_t'($urandom_range(0, SAMPLE_MAX)),
				              lspe_pkg::sample_t'($urandom_range(0, SAMPLE_MAX)),
				              lspe_pkg::sample_t'($urandom_range(0, SAMPLE_MAX)));
				default: set_config(lspe_pkg::sample_t'($urandom_range(0, SAMPLE_MAX)),
				                    lspe_pkg::sample_t'($urandom_range(0, 1000)),
				                    lspe_pkg::sample_t'($urandom_range(1000, SAMPLE_MAX)),
				                    lspe_pkg::sample_t'($urandom_range(0, 2000)));
			endcase
			for (n = 0; n < SWEEP_FRAMES; n++) begin
				make_track_frame(f);
				send_frame(f);
			end
		end
	endtask

	// Short bursts of frames, each followed by a pause until every result is back.
	task automatic test_drain_pauses();
		frame_t f;
		int     k;
		int     n;
		set_config(lspe_pkg::FIRST_THRESHOLD_RST, lspe_pkg::WHITE_LIMIT_RST,
		           lspe_pkg::BLACK_LIMIT_RST, lspe_pkg::STEP_LIMIT_RST);
		for (k = 0; k < 5; k++) begin
			for (n = 0; n < 20; n++) begin
				make_track_frame(f);
				send_frame(f);
			end
			drain(0);
		end
	endtask

	// Full rate on both sides, no gaps and no stalls.
	task automatic test_back_to_back();
		frame_t f;
		int     n;
		bursts_on = 1'b0;
		for (n = 0; n < 350; n++) begin
			make_track_frame(f);
			send_frame(f);
		end
	endtask

	// Reset, then the tests in turn, then the final verdict.
	initial begin
		frame_ch.valid    <= 1'b0;
		frame_ch.sample_0 <= '0;
		frame_ch.sample_1 <= '0;
		frame_ch.sample_2 <= '0;
		frame_ch.sample_3 <= '0;
		frame_ch.sample_4 <= '0;
		frame_ch.sample_5 <= '0;
		frame_ch.sample_6 <= '0;
		frame_ch.sample_7 <= '0;
		frame_ch.sample_8 <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_first_frame();
		test_directed_cases();
		test_register_sweep();
		test_drain_pauses();
		test_back_to_back();
		drain(SETTLE_CYCLES);

		$display("Run covered %0d frames under %0d register settings, with gaps, stalls and",
			frames_sent, settings_used);
		$display("a full-rate tail; %0d results checked, %0d of them with the line lost.",
			results_checked, lost_seen);
		if (errors == 0 && expected_centroids.size() == 0) begin
			$display("** line_sensor_position_estimator_top: PASSED **");
		end else begin
			$display("** line_sensor_position_estimator_top: FAILED **");
		end
		$finish;
	end

endmodule

// ----- line_sensor_position_estimator_top.f -----
rtl/core/lspe_pkg.sv
rtl/core/lspe_if.sv
rtl/core/lspe_cell.sv
rtl/core/lspe_div.sv
rtl/core/line_sensor_position_estimator_top.sv
tb/tb_line_sensor_position_estimator_top.sv
